[hdl/qoie_pkg.sv]
`timescale 1ns / 1ps

package qoie_pkg;

  // Register indexes of the configuration port (byte address = 4 * index).
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FORMAT = 2'd2;
  localparam int         ADDR_W     = 4;

  // Pixel formats.
  localparam logic [1:0] FMT_GRAY = 2'd0;
  localparam logic [1:0] FMT_BGR  = 2'd1;
  localparam logic [1:0] FMT_BGRA = 2'd2;

  // Op codes of the byte stream.
  localparam logic [7:0] OP_DIFF     = 8'h40;
  localparam logic [7:0] OP_LUMA     = 8'h80;
  localparam logic [7:0] OP_RUN      = 8'hC0;
  localparam logic [7:0] OP_RUN_FULL = 8'hFD;
  localparam logic [7:0] OP_RGB      = 8'hFE;
  localparam logic [7:0] OP_RGBA     = 8'hFF;
  localparam logic [5:0] RUN_MAX     = 6'd62;

  // Hash weights of the color table index.
  localparam logic [5:0] HASH_R = 6'd3;
  localparam logic [5:0] HASH_G = 6'd5;
  localparam logic [5:0] HASH_B = 6'd7;
  localparam logic [5:0] HASH_A = 6'd11;

  // Header and end marker.
  localparam logic [31:0] MAGIC         = 32'h716F6966;
  localparam logic [7:0]  CH_RGB        = 8'd3;
  localparam logic [7:0]  CH_RGBA       = 8'd4;
  localparam logic [7:0]  COLORSPACE    = 8'h00;
  localparam logic [7:0]  END_LAST_BYTE = 8'h01;
  localparam logic [3:0]  HDR_LAST_IDX  = 4'd13;
  localparam logic [3:0]  END_LAST_IDX  = 4'd7;

  localparam logic [31:0] PREV_RESET = 32'h000000FF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Work handed from the front part to the back part for one pixel.
  typedef struct packed {
    logic            hdr;       // header comes first
    logic            pre_vld;   // run op ahead of the pixel op
    logic [7:0]      pre_byte;
    logic [2:0]      op_len;    // bytes of the pixel op, 0 to 5
    logic [4:0][7:0] op_bytes;  // element 0 goes out first
    logic            post_vld;  // run flushed at the end of the image
    logic [7:0]      post_byte;
    logic            eoi;       // end marker follows
  } job_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_HDR,
    PH_PRE,
    PH_OP,
    PH_POST,
    PH_END
  } phase_t;

endpackage

[hdl/qoie_front.sv]
`timescale 1ns / 1ps

module qoie_front #(
  parameter int DIM_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          pix_blue,
  input  logic [7:0]          pix_green,
  input  logic [7:0]          pix_red,
  input  logic [7:0]          pix_alpha,
  input  logic [DIM_BITS-1:0] image_width,
  input  logic [DIM_BITS-1:0] image_height,
  input  logic [1:0]          pixel_format,
  output qoie_pkg::job_t      job,
  output logic                job_valid,
  input  logic                job_ready
);

  localparam int CNT_W = 2 * DIM_BITS;

  // Stage 0: format conversion and hash.
  logic [31:0] s0_px;
  logic [5:0]  s0_h;
  logic        s1_load;

  // Stage 1: classification.
  logic        s1_valid;
  logic [31:0] s1_px;
  logic [5:0]  s1_h;
  logic        s1_fire;

  logic [31:0] prev_color;
  logic [5:0]  run;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] total;

  logic [31:0] ctab_mem [64];
  logic [31:0] ctab_rd;
  logic [63:0] ctab_vld;
  logic        byp_vld;
  logic [5:0]  byp_h;
  logic [31:0] byp_px;

  logic              eq;
  logic              byp_hit;
  logic [31:0]       entry;
  logic              hit;
  logic signed [7:0] dr;
  logic signed [7:0] dg;
  logic signed [7:0] db;
  logic signed [8:0] dr_dg;
  logic signed [8:0] db_dg;
  logic [7:0]        diff_r;
  logic [7:0]        diff_g;
  logic [7:0]        diff_b;
  logic [8:0]        luma_rg;
  logic [8:0]        luma_bg;
  logic [CNT_W-1:0]  cnt_inc;
  logic              last;
  logic [5:0]        run_inc;
  logic [5:0]        run_after;
  logic              wr_want;
  logic              wr_en;

  always_comb begin
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] a;
    r = (pixel_format == qoie_pkg::FMT_GRAY) ? pix_blue : pix_red;
    g = (pixel_format == qoie_pkg::FMT_GRAY) ? pix_blue : pix_green;
    a = pixel_format[1] ? pix_alpha : 8'hFF;
    s0_px = {r, g, pix_blue, a};
    s0_h  = r[5:0] * qoie_pkg::HASH_R + g[5:0] * qoie_pkg::HASH_G
          + pix_blue[5:0] * qoie_pkg::HASH_B + a[5:0] * qoie_pkg::HASH_A;
  end

  assign in_ready = !s1_valid || s1_fire;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_px <= s0_px;
      s1_h  <= s0_h;
    end
    total <= CNT_W'(image_width) * CNT_W'(image_height);
  end

  always_comb begin
    eq      = s1_px == prev_color;
    byp_hit = byp_vld && (byp_h == s1_h);
    entry   = byp_hit ? byp_px : (ctab_vld[s1_h] ? ctab_rd : 32'h0);
    hit     = entry == s1_px;
    dr      = s1_px[31:24] - prev_color[31:24];
    dg      = s1_px[23:16] - prev_color[23:16];
    db      = s1_px[15:8]  - prev_color[15:8];
    dr_dg   = {dr[7], dr} - {dg[7], dg};
    db_dg   = {db[7], db} - {dg[7], dg};
    diff_r  = dr + 8'sd2;
    diff_g  = dg + 8'sd2;
    diff_b  = db + 8'sd2;
    luma_rg = dr_dg + 9'sd8;
    luma_bg = db_dg + 9'sd8;
    cnt_inc = cnt + 1'b1;
    last    = cnt_inc >= total;
    run_inc = run + 6'd1;

    job       = '0;
    job.hdr   = cnt == '0;
    run_after = run;
    wr_want   = 1'b0;
    if (eq) begin
      if (run_inc == qoie_pkg::RUN_MAX) begin
        job.pre_vld  = 1'b1;
        job.pre_byte = qoie_pkg::OP_RUN_FULL;
        run_after    = 6'd0;
      end else begin
        run_after = run_inc;
      end
    end else begin
      if (run != 6'd0) begin
        job.pre_vld  = 1'b1;
        job.pre_byte = qoie_pkg::OP_RUN | {2'b00, 6'(run - 6'd1)};
      end
      run_after = 6'd0;
      if (hit) begin
        job.op_len      = 3'd1;
        job.op_bytes[0] = {2'b00, s1_h};
      end else begin
        wr_want = 1'b1;
        if (s1_px[7:0] != prev_color[7:0]) begin
          job.op_len      = 3'd5;
          job.op_bytes[0] = qoie_pkg::OP_RGBA;
          job.op_bytes[1] = s1_px[31:24];
          job.op_bytes[2] = s1_px[23:16];
          job.op_bytes[3] = s1_px[15:8];
          job.op_bytes[4] = s1_px[7:0];
        end else if (dr >= -8'sd2 && dr <= 8'sd1 && dg >= -8'sd2 && dg <= 8'sd1 &&
                     db >= -8'sd2 && db <= 8'sd1) begin
          job.op_len      = 3'd1;
          job.op_bytes[0] = qoie_pkg::OP_DIFF | {2'b00, diff_r[1:0], diff_g[1:0], diff_b[1:0]};
        end else if (dg >= -8'sd32 && dg <= 8'sd31 && dr_dg >= -9'sd8 && dr_dg <= 9'sd7 &&
                     db_dg >= -9'sd8 && db_dg <= 9'sd7) begin
          job.op_len      = 3'd2;
          job.op_bytes[0] = qoie_pkg::OP_LUMA | {2'b00, 6'(dg + 8'sd32)};
          job.op_bytes[1] = {luma_rg[3:0], luma_bg[3:0]};
        end else begin
          job.op_len      = 3'd4;
          job.op_bytes[0] = qoie_pkg::OP_RGB;
          job.op_bytes[1] = s1_px[31:24];
          job.op_bytes[2] = s1_px[23:16];
          job.op_bytes[3] = s1_px[15:8];
        end
      end
    end
    if (last) begin
      job.eoi = 1'b1;
      if (run_after != 6'd0) begin
        job.post_vld  = 1'b1;
        job.post_byte = qoie_pkg::OP_RUN | {2'b00, 6'(run_after - 6'd1)};
      end
    end
    job_valid = s1_valid && (job.hdr || job.pre_vld || (job.op_len != 3'd0) || last);
    s1_fire   = s1_valid && (!job_valid || job_ready);
    wr_en     = s1_fire && wr_want && !last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_color <= qoie_pkg::PREV_RESET;
      run        <= 6'd0;
      cnt        <= '0;
      ctab_vld   <= '0;
      byp_vld    <= 1'b0;
    end else begin
      if (s1_fire) begin
        if (last) begin
          prev_color <= qoie_pkg::PREV_RESET;
          run        <= 6'd0;
          cnt        <= '0;
          ctab_vld   <= '0;
        end else begin
          prev_color <= s1_px;
          run        <= run_after;
          cnt        <= cnt_inc;
          if (wr_en) begin
            ctab_vld[s1_h] <= 1'b1;
          end
        end
      end
      // The table read for the incoming pixel happens at the same edge as
      // this write, so the written entry is kept aside for one comparison.
      if (s1_load) begin
        byp_vld <= wr_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      byp_h  <= s1_h;
      byp_px <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ctab_mem[s1_h] <= s1_px;
    end
    if (s1_load) begin
      ctab_rd <= ctab_mem[s0_h];
    end
  end

`ifndef SYNTHESIS
  a_image_restart: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && last) |=> (cnt == '0 && run == 6'd0 && ctab_vld == '0))
    else $error("state not cleared after the last pixel");
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run < qoie_pkg::RUN_MAX)
    else $error("run length reached its flush value");
`endif

endmodule

[hdl/qoie_queue.sv]
`timescale 1ns / 1ps

module qoie_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  qoie_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output qoie_pkg::job_t pop_job
);

  qoie_pkg::job_t mem [qoie_pkg::QUEUE_DEPTH];
  logic [qoie_pkg::QPTR_W-1:0] wr_ptr;
  logic [qoie_pkg::QPTR_W-1:0] rd_ptr;
  logic [qoie_pkg::QPTR_W:0]   count;
  logic push;
  logic pop;

  assign push_ready = count != (qoie_pkg::QPTR_W+1)'(qoie_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end else begin
        count <= count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (qoie_pkg::QPTR_W+1)'(qoie_pkg::QUEUE_DEPTH))
    else $error("queue count beyond its depth");
`endif

endmodule

[hdl/qoie_back.sv]
`timescale 1ns / 1ps

module qoie_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  qoie_pkg::job_t job,
  input  logic [31:0]    hdr_width,
  input  logic [31:0]    hdr_height,
  input  logic [7:0]     hdr_channels,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last_for_pixel,
  output logic           end_of_image
);

  qoie_pkg::phase_t ph;
  qoie_pkg::phase_t ph_next;
  qoie_pkg::phase_t cur_ph;
  qoie_pkg::phase_t nxt_ph;
  logic [3:0]   idx;
  logic [3:0]   idx_next;
  logic [3:0]   cur_idx;
  logic [111:0] hdr_vec;
  logic [7:0]   byte_sel;
  logic         phase_done;
  logic         job_last;
  logic         load;

  // First phase after cur that this job has, PH_START when none is left.
  function automatic qoie_pkg::phase_t next_phase(input qoie_pkg::job_t j,
                                                  input qoie_pkg::phase_t cur);
    logic past_hdr;
    logic past_pre;
    logic past_op;
    logic past_post;
    past_hdr  = cur != qoie_pkg::PH_START;
    past_pre  = past_hdr && cur != qoie_pkg::PH_HDR;
    past_op   = past_pre && cur != qoie_pkg::PH_PRE;
    past_post = past_op && cur != qoie_pkg::PH_OP;
    priority if (!past_hdr && j.hdr) begin
      return qoie_pkg::PH_HDR;
    end else if (!past_pre && j.pre_vld) begin
      return qoie_pkg::PH_PRE;
    end else if (!past_op && j.op_len != 3'd0) begin
      return qoie_pkg::PH_OP;
    end else if (!past_post && j.post_vld) begin
      return qoie_pkg::PH_POST;
    end else if (cur != qoie_pkg::PH_END && j.eoi) begin
      return qoie_pkg::PH_END;
    end else begin
      return qoie_pkg::PH_START;
    end
  endfunction

  assign hdr_vec = {qoie_pkg::MAGIC, hdr_width, hdr_height, hdr_channels, qoie_pkg::COLORSPACE};
  assign load    = job_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph  <= qoie_pkg::PH_START;
      idx <= 4'd0;
    end else begin
      ph  <= ph_next;
      idx <= idx_next;
    end
  end

  always_comb begin
    cur_ph  = (ph == qoie_pkg::PH_START) ? next_phase(job, qoie_pkg::PH_START) : ph;
    cur_idx = (ph == qoie_pkg::PH_START) ? 4'd0 : idx;
    unique case (cur_ph)
      qoie_pkg::PH_HDR: begin
        byte_sel   = hdr_vec[7'(qoie_pkg::HDR_LAST_IDX - cur_idx) * 8 +: 8];
        phase_done = cur_idx == qoie_pkg::HDR_LAST_IDX;
      end
      qoie_pkg::PH_PRE: begin
        byte_sel   = job.pre_byte;
        phase_done = 1'b1;
      end
      qoie_pkg::PH_OP: begin
        byte_sel   = job.op_bytes[cur_idx[2:0]];
        phase_done = cur_idx == {1'b0, 3'(job.op_len - 3'd1)};
      end
      qoie_pkg::PH_POST: begin
        byte_sel   = job.post_byte;
        phase_done = 1'b1;
      end
      qoie_pkg::PH_END: begin
        byte_sel   = (cur_idx == qoie_pkg::END_LAST_IDX) ? qoie_pkg::END_LAST_BYTE : 8'h00;
        phase_done = cur_idx == qoie_pkg::END_LAST_IDX;
      end
      default: begin
        byte_sel   = 8'h00;
        phase_done = 1'b1;
      end
    endcase
    nxt_ph    = phase_done ? next_phase(job, cur_ph) : cur_ph;
    job_last  = phase_done && (nxt_ph == qoie_pkg::PH_START);
    job_ready = load && job_last;
    ph_next   = ph;
    idx_next  = idx;
    if (load) begin
      ph_next  = nxt_ph;
      idx_next = phase_done ? 4'd0 : cur_idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= byte_sel;
      last_for_pixel <= job_last;
      end_of_image   <= (cur_ph == qoie_pkg::PH_END) && phase_done;
    end
  end

`ifndef SYNTHESIS
  a_eoi_closes_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_image) |-> last_for_pixel)
    else $error("end of image on a byte that does not close its pixel");
  a_job_ends_at_start: assert property (@(posedge clk) disable iff (rst)
    job_ready |=> (ph == qoie_pkg::PH_START))
    else $error("sequencer not back at job start after a pop");
`endif

endmodule

[hdl/qoi_image_encoder_core.sv]
`timescale 1ns / 1ps

// Channel     Handshake                Payload
// pixel in    in_valid / in_ready      pix_blue, pix_green, pix_red, pix_alpha
// bytes out   out_valid / out_ready    out_byte, last_for_pixel, end_of_image
// config      psel/penable/pwrite      paddr, pwdata, prdata (pready tied high)
//
// The front part takes one pixel per cycle unless a full queue holds it
// back; it converts the format, hashes the color, reads the 64-entry color
// table and picks the op in a second stage. The back part sends one byte
// per cycle while out_ready is high, from a four-job queue. A pixel gives no
// byte for a run extension, one when it completes a run of 62, one to five
// for an op plus one more when a pending run is flushed ahead of it, 14 more
// for the header, and eight for the end marker plus one for a run flushed at the end.
// A pixel's first byte passes the stage-1 register, the queue and the output register.
// Synchronous reset clears the previous color, the run, the pixel count and
// the valid bits of the color table at once; no clearing pass is needed.
// Either side may stall on its own: the queue and the output register absorb
// back pressure, and the front keeps taking pixels until the queue fills.

module qoi_image_encoder_core #(
  parameter int DIM_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  pix_blue,
  input  logic [7:0]                  pix_green,
  input  logic [7:0]                  pix_red,
  input  logic [7:0]                  pix_alpha,
  // byte output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        last_for_pixel,
  output logic                        end_of_image,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qoie_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [DIM_BITS-1:0] image_width;
  logic [DIM_BITS-1:0] image_height;
  logic [1:0]          pixel_format;
  logic                cfg_wr;

  qoie_pkg::job_t f_job;
  qoie_pkg::job_t q_job;
  logic           f_valid;
  logic           f_ready;
  logic           q_valid;
  logic           q_ready;

  // A register write lands at the access beat of the APB transfer.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_BITS'(1);
      image_height <= DIM_BITS'(1);
      pixel_format <= qoie_pkg::FMT_BGRA;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        qoie_pkg::REG_WIDTH:  image_width  <= pwdata[DIM_BITS-1:0];
        qoie_pkg::REG_HEIGHT: image_height <= pwdata[DIM_BITS-1:0];
        qoie_pkg::REG_FORMAT: pixel_format <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      qoie_pkg::REG_WIDTH:  prdata = 32'(image_width);
      qoie_pkg::REG_HEIGHT: prdata = 32'(image_height);
      qoie_pkg::REG_FORMAT: prdata = 32'(pixel_format);
      default:              prdata = 32'h0;
    endcase
  end

  qoie_front #(
    .DIM_BITS(DIM_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pix_blue     (pix_blue),
    .pix_green    (pix_green),
    .pix_red      (pix_red),
    .pix_alpha    (pix_alpha),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel_format (pixel_format),
    .job          (f_job),
    .job_valid    (f_valid),
    .job_ready    (f_ready)
  );

  qoie_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  // The header reads the registers directly: the user must change them only while
  // the encoder is idle, so no header is in flight; the block does not enforce it.
  qoie_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_valid),
    .job_ready      (q_ready),
    .job            (q_job),
    .hdr_width      (32'(image_width)),
    .hdr_height     (32'(image_height)),
    .hdr_channels   (pixel_format[1] ? qoie_pkg::CH_RGBA : qoie_pkg::CH_RGB),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last_for_pixel (last_for_pixel),
    .end_of_image   (end_of_image)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
    else $error("output beat changed while stalled");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the QOI encoder core. Pixels go in one beat at a
// time, encoded bytes come out one beat at a time, and every output beat is
// compared with a byte stream predicted from the pixels that were accepted.
module testbench;
  import qoie_pkg::*;

  localparam int SETTLE_CYCLES  = 8;     // front pipeline plus job queue
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TOTAL_PIXELS   = 450;   // directed and random, at least this many in all
  localparam int REGIME_PIXELS  = 160;
  localparam int MAX_REPORTS    = 10;

  // Format code three is not named by the package; the encoder treats it as BGRA.
  localparam logic [1:0] FMT_ALT_BGRA = 2'd3;
  localparam logic [7:0] END_PAD_BYTE = 8'h00;

  // One expected output beat.
  typedef struct packed {
    logic [7:0] data;
    logic       last_pix;
    logic       eoi;
  } stream_byte_t;

  // The scoreboard carries its own copy of the encoder state and registers.
  // Each accepted pixel is encoded into a burst of expected beats, and every
  // output beat is checked against the oldest beat still waiting.
  class qoi_stream_scoreboard;
    logic [15:0]     width_reg;
    logic [15:0]     height_reg;
    logic [1:0]      format_reg;
    logic [31:0]     prev_color;   // {r, g, b, a}
    logic [5:0]      run_len;
    logic [31:0]     color_index [64];
    longint unsigned pixels_seen;
    stream_byte_t    expected_bytes [$];
    stream_byte_t    burst [$];
    int              errors;
    int              bytes_checked;

    function new();
      width_reg     = 16'd1;
      height_reg    = 16'd1;
      format_reg    = FMT_BGRA;
      errors        = 0;
      bytes_checked = 0;
      restart_image();
    endfunction

    function void restart_image();
      prev_color  = PREV_RESET;
      run_len     = '0;
      pixels_seen = 0;
      foreach (color_index[i]) color_index[i] = '0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] data);
      case (idx)
        REG_WIDTH:  width_reg  = data[15:0];
        REG_HEIGHT: height_reg = data[15:0];
        REG_FORMAT: format_reg = data[1:0];
        default: ;
      endcase
    endfunction

    function void emit(input logic [7:0] data);
      burst.push_back({data, 2'b00});
    endfunction

    function void emit_word(input logic [31:0] word);
      emit(word[31:24]);
      emit(word[23:16]);
      emit(word[15:8]);
      emit(word[7:0]);
    endfunction

    // Channel difference with 8-bit wrap, read as a signed value.
    function int wrap_delta(input logic [7:0] cur, input logic [7:0] old);
      logic signed [7:0] d;
      d = cur - old;
      return d;
    endfunction

    function bit in_span(input int v, input int lo, input int hi);
      return (v >= lo) && (v <= hi);
    endfunction

    function void note_pixel(input logic [7:0] b_in, input logic [7:0] g_in,
                             input logic [7:0] r_in, input logic [7:0] a_in);
      logic [7:0]      r, g, b, a, pr, pg, pb, pa;
      logic [31:0]     px;
      logic [5:0]      slot;
      logic            is_bgra, at_end;
      int              dr, dg, db, dr_dg, db_dg;
      longint unsigned total;

      is_bgra = (format_reg >= FMT_BGRA);
      b = b_in;
      g = (format_reg == FMT_GRAY) ? b_in : g_in;
      r = (format_reg == FMT_GRAY) ? b_in : r_in;
      a = is_bgra ? a_in : 8'd255;
      burst.delete();

      if (pixels_seen == 0) begin
        emit_word(MAGIC);
        emit_word({16'd0, width_reg});
        emit_word({16'd0, height_reg});
        emit(is_bgra ? CH_RGBA : CH_RGB);
        emit(COLORSPACE);
      end

      total = 64'(width_reg) * 64'(height_reg);
      pixels_seen++;
      at_end = (pixels_seen >= total);

      {pr, pg, pb, pa} = prev_color;
      px = {r, g, b, a};
      prev_color = px;

      if (px == {pr, pg, pb, pa}) begin
        run_len++;
        if (run_len == RUN_MAX) begin
          emit(OP_RUN_FULL);
          run_len = '0;
        end
      end else begin
        if (run_len != 0) begin
          emit(OP_RUN | {2'b00, run_len - 6'd1});
          run_len = '0;
        end
        slot = r * HASH_R + g * HASH_G + b * HASH_B + a * HASH_A;
        if (color_index[slot] == px) begin
          emit({2'b00, slot});
        end else begin
          color_index[slot] = px;
          dr    = wrap_delta(r, pr);
          dg    = wrap_delta(g, pg);
          db    = wrap_delta(b, pb);
          dr_dg = dr - dg;
          db_dg = db - dg;
          if (a != pa) begin
            emit(OP_RGBA);
            emit(r);
            emit(g);
            emit(b);
            emit(a);
          end else if (in_span(dr, -2, 1) && in_span(dg, -2, 1) && in_span(db, -2, 1)) begin
            emit(OP_DIFF | {2'b00, 2'(dr + 2), 2'(dg + 2), 2'(db + 2)});
          end else if (in_span(dg, -32, 31) && in_span(dr_dg, -8, 7) &&
                       in_span(db_dg, -8, 7)) begin
            emit(OP_LUMA | {2'b00, 6'(dg + 32)});
            emit({4'(dr_dg + 8), 4'(db_dg + 8)});
          end else begin
            emit(OP_RGB);
            emit(r);
            emit(g);
            emit(b);
          end
        end
      end

      if (at_end) begin
        if (run_len != 0) emit(OP_RUN | {2'b00, run_len - 6'd1});
        repeat (7) emit(END_PAD_BYTE);
        emit(END_LAST_BYTE);
        burst[burst.size() - 1].eoi = 1'b1;
        restart_image();
      end

      if (burst.size() > 0) begin
        burst[burst.size() - 1].last_pix = 1'b1;
        foreach (burst[i]) expected_bytes.push_back(burst[i]);
      end
    endfunction

    function void report(input string what);
      if (errors < MAX_REPORTS) $display("%0t: %s", $time, what);
      errors++;
    endfunction

    function void check_byte(input logic [7:0] data, input logic last_pix, input logic eoi);
      stream_byte_t want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte %0d: got %02h last %0b eoi %0b with nothing pending",
                         bytes_checked, data, last_pix, eoi));
        return;
      end
      want = expected_bytes.pop_front();
      if (want !== {data, last_pix, eoi}) begin
        report($sformatf("byte %0d: expected %02h last %0b eoi %0b, got %02h last %0b eoi %0b",
                         bytes_checked, want.data, want.last_pix, want.eoi,
                         data, last_pix, eoi));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        pix_blue;
  logic [7:0]        pix_green;
  logic [7:0]        pix_red;
  logic [7:0]        pix_alpha;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_byte;
  logic              last_for_pixel;
  logic              end_of_image;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  qoi_stream_scoreboard stream_sb;

  // Idle rates in percent per cycle for the pixel sender and the byte receiver.
  int tx_idle_pct  = 10;
  int rx_stall_pct = 46;
  int quiet_cycles = 0;
  int pixels_sent  = 0;

  // Pixel generator state. Colors are packed as {r, g, b, a}.
  logic [31:0] last_sent;
  logic [31:0] palette [8];
  int          run_left;

  qoi_image_encoder_core #(
    .DIM_BITS(16)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pix_blue       (pix_blue),
    .pix_green      (pix_green),
    .pix_red        (pix_red),
    .pix_alpha      (pix_alpha),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last_for_pixel (last_for_pixel),
    .end_of_image   (end_of_image),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both channels are sampled at the rising edge, before any of the values
  // driven at that edge take effect. A pixel beat is noted before an output
  // beat is checked, so a byte can never be seen ahead of its own pixel. The
  // receiver also picks its ready for the next cycle here, and the quiet
  // counter restarts on any beat or any configuration traffic.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      stream_sb.note_pixel(pix_blue, pix_green, pix_red, pix_alpha);
    end
    if (!rst && out_valid && out_ready) begin
      stream_sb.check_byte(out_byte, last_for_pixel, end_of_image);
    end
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The run is stopped when nothing moves on any port for too long.
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one pixel and returns at the edge where its beat is accepted. The
  // valid is left high, so a following call in the same step keeps it high
  // for a back-to-back beat; any other caller must lower it first.
  task automatic send_pixel(input logic [31:0] px);
    if (pixels_sent < REGIME_PIXELS) begin
      tx_idle_pct  = 10;
      rx_stall_pct = 46;
    end else if (pixels_sent < 2 * REGIME_PIXELS) begin
      tx_idle_pct  = 46;
      rx_stall_pct = 10;
    end else begin
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
    end
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    {pix_red, pix_green, pix_blue, pix_alpha} <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    last_sent = px;
    palette[$urandom_range(0, 7)] = px;
  endtask

  // Stops offering pixels and waits until every predicted byte has come out,
  // then lets the pipeline settle, since a pixel that only extends a run
  // leaves nothing behind to wait for.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (stream_sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // A setup phase, then an access phase; the register takes the value at the
  // access edge. An idle phase follows so that back-to-back writes never
  // lower and raise psel in the same step.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    stream_sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Register writes only happen with the encoder idle. The unused upper bits
  // carry random values, which the encoder must drop.
  task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic [1:0] fmt);
    drain(SETTLE_CYCLES);
    write_reg(REG_WIDTH, {16'($urandom), w});
    write_reg(REG_HEIGHT, {16'($urandom), h});
    write_reg(REG_FORMAT, {30'($urandom), fmt});
  endtask

  // Mostly image-like pixels: runs (a few long enough to hit the full-run
  // op), repeats of recent colors for index hits, small and medium steps for
  // the diff and luma ops, alpha changes, and some fully random noise.
  function automatic logic [31:0] next_pixel();
    logic [7:0] r, g, b, a;
    int         pick;
    int         dg;
    {r, g, b, a} = last_sent;
    if (run_left > 0) begin
      run_left--;
      return last_sent;
    end
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(58, 66) : $urandom_range(0, 4);
      return last_sent;
    end else if (pick < 30) begin
      return palette[$urandom_range(0, 7)];
    end else if (pick < 50) begin
      r = r + 8'($urandom_range(0, 3)) - 8'd2;
      g = g + 8'($urandom_range(0, 3)) - 8'd2;
      b = b + 8'($urandom_range(0, 3)) - 8'd2;
    end else if (pick < 65) begin
      dg = $urandom_range(0, 63) - 32;
      g  = g + 8'(dg);
      r  = r + 8'(dg + $urandom_range(0, 15) - 8);
      b  = b + 8'(dg + $urandom_range(0, 15) - 8);
    end else if (pick < 75) begin
      a = 8'($urandom);
    end else if (pick < 82) begin
      r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      {r, g, b, a} = $urandom;
    end
    return {r, g, b, a};
  endfunction

  initial begin : stimulus
    logic [15:0] w;
    logic [15:0] h;
    int          n;

    stream_sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    pix_blue  <= '0;
    pix_green <= '0;
    pix_red   <= '0;
    pix_alpha <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    last_sent = PREV_RESET;
    run_left  = 0;
    foreach (palette[i]) palette[i] = PREV_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers left at reset: 1 x 1 BGRA, so every pixel is a whole image.
    // The first pixel matches the reset color and becomes a one-pixel run
    // flushed before the end marker; the second is an RGBA op at the extremes.
    send_pixel(PREV_RESET);
    send_pixel(32'hFFFFFF00);

    // A 4 x 2 image that walks through diff, luma, RGB, RGBA and an index
    // hit, and ends inside a run of three so the run is flushed at the end.
    configure(16'd4, 16'd2, FMT_BGRA);
    send_pixel(32'hFF0001FF);
    send_pixel(32'h191415FF);
    send_pixel(32'h3264C8FF);
    send_pixel(32'h3264C880);
    send_pixel(32'hFF0001FF);
    send_pixel(32'hFF0001FF);
    send_pixel(32'hFF0001FF);
    send_pixel(32'hFF0001FF);

    // Gray: only the blue lane counts, alpha is forced opaque.
    configure(16'd3, 16'd1, FMT_GRAY);
    send_pixel(32'hA55A003C);
    send_pixel(32'h5AA5FFC3);
    send_pixel(32'h0FF08000);

    // Zero width with format code three: each pixel is a complete image.
    configure(16'd0, 16'd5, FMT_ALT_BGRA);
    send_pixel(32'h10203040);
    send_pixel(32'h10203040);

    // BGR, then the size shrinks mid-image below the count already reached,
    // so the next pixel closes the image.
    configure(16'd10, 16'd10, FMT_BGR);
    send_pixel(32'h80808080);
    send_pixel(32'h7F7F7F00);
    send_pixel(32'h01020304);
    configure(16'd1, 16'd2, FMT_BGR);
    send_pixel(32'h01020304);

    // Largest image size; it stays open until a later, smaller setting lets a pixel close it.
    configure(16'hFFFF, 16'hFFFF, FMT_BGRA);
    send_pixel(32'h00000000);
    send_pixel(32'hFFFFFFFF);

    // Random part: a new register setting for each stretch of pixels. Small
    // images end often, wide rows leave room for full runs, and the largest
    // sizes leave images open until a later setting closes them.
    while (pixels_sent < TOTAL_PIXELS) begin
      case ($urandom_range(0, 7))
        0: begin
          w = 16'd1;
          h = 16'd1;
        end
        1: begin
          w = 16'hFFFF;
          h = 16'($urandom_range(1, 3));
        end
        2: begin
          w = 16'($urandom_range(60, 100));
          h = 16'd1;
        end
        3: begin
          w = 16'($urandom_range(1, 4));
          h = 16'hFFFF;
        end
        default: begin
          w = 16'($urandom_range(1, 10));
          h = 16'($urandom_range(1, 8));
        end
      endcase
      configure(w, h, 2'($urandom_range(0, 3)));
      n = $urandom_range(8, 90);
      repeat (n) send_pixel(next_pixel());
    end

    drain(DRAIN_CYCLES);
    if (stream_sb.errors == 0 && stream_sb.expected_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
